FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks, disabled while reset is low

`ifndef SYNTHESIS

`define TTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

`define TTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define TTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`define TTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/ttc_pkg.sv
`default_nettype none

package ttc_pkg;

	localparam int MinCellMvDef = 3000;
	localparam int MaxCellMvDef = 4200;

	localparam int CoefW  = 48;
	localparam int ThrW   = 32;
	localparam int VoltW  = 24;
	localparam int CmdW   = 16;
	localparam int RadW   = 98;
	localparam int RootW  = 49;
	localparam int RemW   = 51;
	localparam int DW     = 49;
	localparam int DenW   = 50;
	localparam int QW     = 16;

	typedef enum logic [2:0] {
		REG_COEF_QUAD   = 3'd0,
		REG_COEF_LIN    = 3'd1,
		REG_COEF_OFF    = 3'd2,
		REG_COMP_EN     = 3'd3,
		REG_RATIO_SLOPE = 3'd4,
		REG_RATIO_ICPT  = 3'd5,
		REG_CELL_COUNT  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DW-1:0] d;
		logic          skipped;
		logic          invalid;
	} side_t;

	typedef struct packed {
		logic [RadW-1:0]  rad;
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
		side_t            side;
	} sq_t;

	typedef struct packed {
		logic [DenW-1:0] rem;
		logic [QW-1:0]   nlo;
		logic [QW-1:0]   quo;
		logic [DenW-1:0] den;
		logic            skipped;
		logic            invalid;
		logic            neg;
		logic            sat;
	} dv_t;

endpackage

`default_nettype wire

FILE: rtl/ttc_sqrt_cell.sv
`default_nettype none

module ttc_sqrt_cell import ttc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sq_t  din,
	output logic out_valid,
	output sq_t  dout
);

	logic [RemW+1:0] rem_sh;
	logic [RemW-1:0] trial;
	logic            fits;
	sq_t             nxt;
	sq_t             dout_q;
	logic            valid_q;

	always_comb begin
		rem_sh = {din.rem, din.rad[RadW-1 -: 2]};
		trial  = {din.root, 2'b01};
		fits   = rem_sh >= {2'b00, trial};
		nxt    = din;
		nxt.rad = {din.rad[RadW-3:0], 2'b00};
		if (fits) begin
			nxt.rem  = RemW'(rem_sh - {2'b00, trial});
			nxt.root = {din.root[RootW-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh[RemW-1:0];
			nxt.root = {din.root[RootW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign dout      = dout_q;

endmodule

`default_nettype wire

FILE: rtl/ttc_div_cell.sv
`default_nettype none

module ttc_div_cell import ttc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  dv_t  din,
	output logic out_valid,
	output dv_t  dout
);

	logic [DenW:0] rem_sh;
	logic          fits;
	dv_t           nxt;
	dv_t           dout_q;
	logic          valid_q;

	always_comb begin
		rem_sh  = {din.rem, din.nlo[QW-1]};
		fits    = rem_sh >= {1'b0, din.den};
		nxt     = din;
		nxt.nlo = {din.nlo[QW-2:0], 1'b0};
		if (fits) begin
			nxt.rem = DenW'(rem_sh - {1'b0, din.den});
			nxt.quo = {din.quo[QW-2:0], 1'b1};
		end else begin
			nxt.rem = rem_sh[DenW-1:0];
			nxt.quo = {din.quo[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign dout      = dout_q;

endmodule

`default_nettype wire

FILE: rtl/thrust_to_command_inverse_map.sv
// channel   | dir | signals                               | contents
// s_axis    | in  | tvalid tready tdata[55:0]             | thrust_demand, supply_volts
// m_axis    | out | tvalid tready tdata[15:0] tuser[1:0]  | motor_command; flags
// cfg       | in  | cfg_we cfg_index[2:0] cfg_data[47:0]  | register writes
//
// one word enters per cycle while the output is not stalled
// most of the pipeline is the square root row (49 cells) and the divide row (16 cells)
// multiplies are cut into 24 to 32 bit partial products over two stages each
// a stalled output holds the whole row; input ready follows output room
// reset clears the config registers and the valid bits, no clearing pass

`default_nettype none

`include "assert_macros.svh"

module thrust_to_command_inverse_map import ttc_pkg::*; #(
	parameter int MIN_CELL_MV = MinCellMvDef,
	parameter int MAX_CELL_MV = MaxCellMvDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // thrust_demand[31:0], supply_volts[55:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // motor_command[15:0]
	output logic [1:0]  m_axis_tuser    // compensation_skipped[0], result_invalid[1]
);

	localparam int NSq  = RootW;
	localparam int NDiv = QW;

	logic [CoefW-1:0] coef_a_q, coef_b_q, coef_c_q, slope_q, icpt_q;
	logic             comp_en_q;
	logic [3:0]       cells_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= '0;
			coef_b_q  <= '0;
			coef_c_q  <= '0;
			comp_en_q <= 1'b0;
			slope_q   <= '0;
			icpt_q    <= '0;
			cells_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COEF_QUAD:   coef_a_q  <= cfg_data;
				REG_COEF_LIN:    coef_b_q  <= cfg_data;
				REG_COEF_OFF:    coef_c_q  <= cfg_data;
				REG_COMP_EN:     comp_en_q <= cfg_data[0];
				REG_RATIO_SLOPE: slope_q   <= cfg_data;
				REG_RATIO_ICPT:  icpt_q    <= cfg_data;
				REG_CELL_COUNT:  cells_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_vld_q;
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// front stages valid
	logic [7:1] vld_q;
	sq_t  sq_d [NSq+1];
	logic sq_v [NSq+1];
	dv_t  dv_d [NDiv+1];
	logic dv_v [NDiv+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[6:1], s_axis_tvalid};
		end
	end

	// stage 1: window test, slope times volts
	logic [ThrW-1:0]  t_in;
	logic [VoltW-1:0] v_in;
	logic [CoefW-1:0] slope_mag;
	logic [33:0]      vm, lo_b, hi_b;
	logic             win;
	logic [ThrW-1:0]  t_s1;
	logic             use_s1, skip_s1;
	logic [47:0]      pl_s1, ph_s1;

	always_comb begin
		t_in      = s_axis_tdata[31:0];
		v_in      = s_axis_tdata[55:32];
		slope_mag = slope_q[CoefW-1] ? CoefW'(0) - slope_q : slope_q;
		vm        = 34'(v_in) * 34'(1000);
		lo_b      = (34'(cells_q) * 34'(MIN_CELL_MV)) << 16;
		hi_b      = (34'(cells_q) * 34'(MAX_CELL_MV)) << 16;
		win       = (vm >= lo_b) && (vm <= hi_b);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_in;
			use_s1  <= comp_en_q && win;
			skip_s1 <= comp_en_q && !win;
			pl_s1   <= slope_mag[23:0] * v_in;
			ph_s1   <= slope_mag[47:24] * v_in;
		end
	end

	// stage 2: ratio
	logic [71:0] rmag72;
	logic [57:0] rsgn;
	logic [ThrW-1:0] t_s2;
	logic        use_s2, skip_s2;
	logic [57:0] ratio_s2;

	always_comb begin
		rmag72 = 72'({ph_s1, 24'd0}) + 72'(pl_s1);
		rsgn   = slope_q[CoefW-1] ? 58'd0 - {2'b00, rmag72[71:16]} : {2'b00, rmag72[71:16]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2     <= t_s1;
			use_s2   <= use_s1;
			skip_s2  <= skip_s1;
			ratio_s2 <= rsgn + {{10{icpt_q[CoefW-1]}}, icpt_q};
		end
	end

	// stage 3: thrust times ratio partial products
	logic [ThrW-1:0] tmag;
	logic [57:0]     ratio_mag;
	logic [ThrW-1:0] t_s3;
	logic            use_s3, skip_s3, neg_s3;
	logic [59:0]     pl_s3, ph_s3;

	always_comb begin
		tmag      = t_s2[ThrW-1] ? ThrW'(0) - t_s2 : t_s2;
		ratio_mag = ratio_s2[57] ? 58'd0 - ratio_s2 : ratio_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3    <= t_s2;
			use_s3  <= use_s2;
			skip_s3 <= skip_s2;
			neg_s3  <= t_s2[ThrW-1] ^ ratio_s2[57];
			pl_s3   <= tmag * ratio_mag[27:0];
			ph_s3   <= tmag * ratio_mag[55:28];
		end
	end

	// stage 4: saturate, offset difference
	logic [87:0]   prod;
	logic [71:0]   cap, msat;
	logic [DW-1:0] ta_c, ta_u, ta;
	logic [DW-1:0] d_s4;
	logic          skip_s4;

	always_comb begin
		prod = 88'({ph_s3, 28'd0}) + 88'(pl_s3);
		cap  = neg_s3 ? 72'h8000_0000_0000 : 72'h7FFF_FFFF_FFFF;
		msat = (prod[87:16] > cap) ? cap : prod[87:16];
		ta_c = neg_s3 ? DW'(0) - msat[DW-1:0] : msat[DW-1:0];
		ta_u = {t_s3[ThrW-1], t_s3, 16'd0};
		ta   = use_s3 ? ta_c : ta_u;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4    <= {coef_c_q[CoefW-1], coef_c_q} - ta;
			skip_s4 <= skip_s3;
		end
	end

	// stage 5: discriminant partial products
	logic [CoefW-1:0] bmag, amag;
	logic [DW-1:0]    dmag;
	logic [DW-1:0]    d_s5;
	logic             skip_s5, sgn_s5;
	logic [47:0]      bb00_s5, bb01_s5, bb11_s5, ad00_s5, ad10_s5;
	logic [48:0]      ad01_s5, ad11_s5;

	always_comb begin
		bmag = coef_b_q[CoefW-1] ? CoefW'(0) - coef_b_q : coef_b_q;
		amag = coef_a_q[CoefW-1] ? CoefW'(0) - coef_a_q : coef_a_q;
		dmag = d_s4[DW-1] ? DW'(0) - d_s4 : d_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s5    <= d_s4;
			skip_s5 <= skip_s4;
			sgn_s5  <= coef_a_q[CoefW-1] ^ d_s4[DW-1];
			bb00_s5 <= bmag[23:0] * bmag[23:0];
			bb01_s5 <= bmag[23:0] * bmag[47:24];
			bb11_s5 <= bmag[47:24] * bmag[47:24];
			ad00_s5 <= amag[23:0] * dmag[23:0];
			ad01_s5 <= amag[23:0] * dmag[48:24];
			ad10_s5 <= amag[47:24] * dmag[23:0];
			ad11_s5 <= amag[47:24] * dmag[48:24];
		end
	end

	// stage 6: sum partial products
	logic [98:0]   ad_sum;
	logic [98:0]   bb_s6, ad_s6;
	logic [DW-1:0] d_s6;
	logic          skip_s6, sgn_s6;

	assign ad_sum = 99'({ad11_s5, 48'd0}) + 99'({ad01_s5, 24'd0}) + 99'({ad10_s5, 24'd0})
		+ 99'(ad00_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s6   <= 99'({bb11_s5, 48'd0}) + 99'({bb01_s5, 25'd0}) + 99'(bb00_s5);
			ad_s6   <= {ad_sum[96:0], 2'b00};
			d_s6    <= d_s5;
			skip_s6 <= skip_s5;
			sgn_s6  <= sgn_s5;
		end
	end

	// stage 7: discriminant, seeds the root row
	logic [98:0] disc;
	logic        neg_disc;
	sq_t         sq_seed;
	sq_t         sq0_q;

	always_comb begin
		neg_disc = 1'b0;
		if (sgn_s6) begin
			disc = bb_s6 + ad_s6;
		end else if (ad_s6 > bb_s6) begin
			disc     = bb_s6;
			neg_disc = 1'b1;
		end else begin
			disc = bb_s6 - ad_s6;
		end
		sq_seed              = '0;
		sq_seed.rad          = disc[RadW-1:0];
		sq_seed.side.d       = d_s6;
		sq_seed.side.skipped = skip_s6;
		sq_seed.side.invalid = neg_disc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq0_q <= sq_seed;
		end
	end

	assign sq_d[0] = sq0_q;
	assign sq_v[0] = vld_q[7];

	for (genvar i = 0; i < NSq; i++) begin : g_sq
		ttc_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (sq_v[i]),
			.din       (sq_d[i]),
			.out_valid (sq_v[i+1]),
			.dout      (sq_d[i+1])
		);
	end

	// stage 8: denominator, divide seed
	logic [50:0]     den51, den_abs;
	logic [DW-1:0]   nmag;
	logic [DenW-1:0] num;
	logic [DenW-1:0] den_mag;
	dv_t             dv_seed;
	dv_t             dv0_q;
	logic            dv0_vld_q;

	always_comb begin
		den51   = 51'd0 - {{3{coef_b_q[CoefW-1]}}, coef_b_q} - {2'b00, sq_d[NSq].root};
		den_abs = den51[50] ? 51'd0 - den51 : den51;
		den_mag = den_abs[DenW-1:0];
		nmag    = sq_d[NSq].side.d[DW-1] ? DW'(0) - sq_d[NSq].side.d : sq_d[NSq].side.d;
		num     = {nmag, 1'b0};
		dv_seed         = '0;
		dv_seed.rem     = {16'd0, num[DenW-1:16]};
		dv_seed.nlo     = num[15:0];
		dv_seed.den     = den_mag;
		dv_seed.skipped = sq_d[NSq].side.skipped;
		dv_seed.invalid = sq_d[NSq].side.invalid || (den51 == 51'd0);
		dv_seed.neg     = sq_d[NSq].side.d[DW-1] ^ den51[50];
		dv_seed.sat     = {16'd0, num[DenW-1:16]} >= den_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv0_vld_q <= 1'b0;
		end else if (adv) begin
			dv0_vld_q <= sq_v[NSq];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv0_q <= dv_seed;
		end
	end

	assign dv_d[0] = dv0_q;
	assign dv_v[0] = dv0_vld_q;

	for (genvar j = 0; j < NDiv; j++) begin : g_div
		ttc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (dv_v[j]),
			.din       (dv_d[j]),
			.out_valid (dv_v[j+1]),
			.dout      (dv_d[j+1])
		);
	end

	// output register
	logic [CmdW-1:0] cmd;
	logic [CmdW-1:0] cmd_q;
	logic [1:0]      flags_q;

	always_comb begin
		if (dv_d[NDiv].invalid || dv_d[NDiv].neg) begin
			cmd = '0;
		end else if (dv_d[NDiv].sat) begin
			cmd = '1;
		end else begin
			cmd = dv_d[NDiv].quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_v[NDiv];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q   <= cmd;
			flags_q <= {dv_d[NDiv].invalid, dv_d[NDiv].skipped};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = cmd_q;
	assign m_axis_tuser  = flags_q;

	`TTC_ASSERT_IMPLY(a_stall_blocks_input, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`TTC_ASSERT_IMPLY(a_invalid_zero_cmd, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0)
	`TTC_ASSERT_IMPLY(a_skip_needs_enable, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], comp_en_q)

endmodule

`default_nettype wire

FILE: tb/tb_thrust_to_command_inverse_map.sv
`default_nettype none

class command_scoreboard;
	typedef struct {
		logic [15:0] cmd;
		logic        skipped;
		logic        invalid;
	} cmd_result_t;

	logic signed [47:0] quad, lin, offs, slope, icpt;
	logic               comp_en;
	logic [3:0]         cells;
	cmd_result_t        pending_cmds[$];
	int                 mismatches;

	function new();
		quad = 0; lin = 0; offs = 0; slope = 0; icpt = 0;
		comp_en = 0; cells = 0; mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [47:0] val);
		case (idx)
			ttc_pkg::REG_COEF_QUAD:   quad = val;
			ttc_pkg::REG_COEF_LIN:    lin = val;
			ttc_pkg::REG_COEF_OFF:    offs = val;
			ttc_pkg::REG_COMP_EN:     comp_en = val[0];
			ttc_pkg::REG_RATIO_SLOPE: slope = val;
			ttc_pkg::REG_RATIO_ICPT:  icpt = val;
			ttc_pkg::REG_CELL_COUNT:  cells = val[3:0];
			default: ;
		endcase
	endfunction

	function logic signed [127:0] isqrt(logic signed [127:0] x);
		logic signed [127:0] r, cand;
		r = 0;
		for (int b = 52; b >= 0; b--) begin
			cand = r | (128'sd1 <<< b);
			if (cand * cand <= x) r = cand;
		end
		return r;
	endfunction

	function void note_demand(logic signed [31:0] t, logic [23:0] v);
		logic signed [127:0] ta, ratio, vs, d, disc, den, q, a, b, c;
		logic [63:0] lo, hi, vm;
		cmd_result_t r;
		a = quad; b = lin; c = offs;
		vs = $signed({104'b0, v});
		ta = t;
		ta = ta * 65536;
		r = '{cmd: 16'd0, skipped: 1'b0, invalid: 1'b0};
		if (comp_en) begin
			lo = 64'(cells) * 3000 * 65536;
			hi = 64'(cells) * 4200 * 65536;
			vm = 64'(v) * 1000;
			if (vm >= lo && vm <= hi) begin
				ratio = 128'(slope) * vs;
				ratio = ratio / 65536 + 128'(icpt);
				ta = t;
				ta = ta * ratio;
				ta = ta / 65536;
				if (ta > 128'sh7FFF_FFFF_FFFF) ta = 128'sh7FFF_FFFF_FFFF;
				if (ta < -128'sh8000_0000_0000) ta = -128'sh8000_0000_0000;
			end else begin
				r.skipped = 1'b1;
			end
		end
		d = c - ta;
		disc = b * b - 4 * a * d;
		if (disc < 0) begin
			r.invalid = 1'b1;
		end else begin
			den = -b - isqrt(disc);
			if (den == 0) begin
				r.invalid = 1'b1;
			end else begin
				q = (2 * d) / den;
				r.cmd = q < 0 ? 16'd0 : (q > 65535 ? 16'hFFFF : q[15:0]);
			end
		end
		pending_cmds.push_back(r);
	endfunction

	function void check_command(logic [15:0] cmd, logic [1:0] flags);
		cmd_result_t e;
		if (pending_cmds.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected word cmd=%0d flags=%b", cmd, flags);
			return;
		end
		e = pending_cmds.pop_front();
		if (cmd !== e.cmd || flags[0] !== e.skipped || flags[1] !== e.invalid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected cmd=%0d skip=%b inv=%b, got cmd=%0d skip=%b inv=%b",
					e.cmd, e.skipped, e.invalid, cmd, flags[0], flags[1]);
		end
	endfunction
endclass

module tb_thrust_to_command_inverse_map;
	timeunit 1ns;
	timeprecision 1ps;
	import ttc_pkg::*;

	localparam logic [2:0] RegUnused = 3'd7;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int gap_pct = 0;
	int stall_pct = 0;
	command_scoreboard sb;

	thrust_to_command_inverse_map dut (.*);

	always #5 clk = ~clk;

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_demand(s_axis_tdata[31:0], s_axis_tdata[55:32]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_command(m_axis_tdata, m_axis_tuser);
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_demand(logic [31:0] t, logic [23:0] v);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			s_axis_tvalid = 0;
		end
		@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = {v, t};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 0;
		while (sb.pending_cmds.size() > 0) @(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic set_flight_config();
		write_reg(REG_COEF_QUAD, 48'($urandom_range(100, 6000)));
		write_reg(REG_COEF_LIN, $urandom_range(3) == 0 ? -48'($urandom_range(0, 1 << 20))
			: 48'($urandom_range(0, 1 << 20)));
		write_reg(REG_COEF_OFF, 48'(signed'(32'($urandom_range(0, 1 << 24)) - (1 << 23))));
		write_reg(REG_COMP_EN, 48'($urandom_range(1)));
		write_reg(REG_RATIO_SLOPE, 48'(signed'(32'($urandom_range(0, 1 << 30)) - (1 << 29))));
		write_reg(REG_RATIO_ICPT, 48'(64'h1_0000_0000 + $urandom_range(0, 1 << 30)));
		write_reg(REG_CELL_COUNT, 48'($urandom_range(1, 12)));
		write_reg(RegUnused, rand48());
	endtask

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [23:0] v, wlo, whi;
		logic [31:0] t;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// all-zero map gives a zero denominator
		send_demand(32'h0001_0000, 24'd0);
		send_demand(32'h8000_0000, 24'hFFFFFF);
		drain();

		write_reg(REG_COEF_QUAD, 48'd1000);
		write_reg(REG_COEF_LIN, 48'd50000);
		write_reg(REG_COEF_OFF, -48'd1000);
		write_reg(REG_COMP_EN, 48'd1);
		write_reg(REG_RATIO_SLOPE, 48'h0000_1000_0000);
		write_reg(REG_RATIO_ICPT, 48'h0000_8000_0000);
		write_reg(REG_CELL_COUNT, 48'd4);
		send_demand(32'h7FFF_FFFF, 24'd900000);
		send_demand(32'h8000_0000, 24'd900000);
		send_demand(32'h0, 24'd900000);
		send_demand(32'hFFFF_FFFF, 24'd900000);
		send_demand(32'h0100_0000, 24'd786432);
		send_demand(32'h0100_0000, 24'd786431);
		send_demand(32'h0100_0000, 24'd1101004);
		send_demand(32'h0100_0000, 24'd1101005);
		send_demand(32'h0100_0000, 24'd0);
		send_demand(32'h0100_0000, 24'hFFFFFF);
		send_demand(32'h0000_0100, 24'd900000);
		drain();
		write_reg(REG_COMP_EN, 48'd0);
		write_reg(REG_COEF_LIN, -48'd50000);
		send_demand(32'h0100_0000, 24'd0);
		send_demand(32'hFF00_0000, 24'd900000);
		send_demand(32'h7FFF_FFFF, 24'd5);
		drain();
		write_reg(REG_CELL_COUNT, 48'd0);
		write_reg(REG_COMP_EN, 48'd1);
		send_demand(32'h0100_0000, 24'd0);
		send_demand(32'h0100_0000, 24'd1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 70; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 70; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			if (ph == 4 || ph == 5) begin
				for (int r = 0; r < 6; r++) if (r != 3)
					write_reg(3'(r), ph == 4 ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000);
				write_reg(REG_COMP_EN, 48'(ph == 4));
				write_reg(REG_CELL_COUNT, ph == 4 ? 48'd15 : 48'd12);
			end else if (ph == 6) begin
				for (int r = 0; r < 8; r++) write_reg(3'(r), rand48());
			end else begin
				set_flight_config();
			end
			wlo = 24'(sb.cells * 196608);
			whi = 24'((64'(sb.cells) * 4200 * 65536) / 1000);
			for (int n = 0; n < 92; n++) begin
				if ($urandom_range(3) != 0) begin
					t = $urandom_range(0, 1 << 24);
					v = 24'($urandom_range(wlo, whi));
				end else begin
					t = $urandom;
					v = 24'($urandom);
				end
				send_demand(t, v);
			end
			gap_pct = 0;
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_cmds.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

`default_nettype wire
